>>> sv/knp3_pkg.sv
package knp3_pkg;

    localparam int SLOT_W     = 6;
    localparam int FIELD_W    = 16;
    localparam int RANK_W     = 2;
    localparam int DIST_OUT_W = 34;
    localparam int CFG_W      = 7;

    localparam logic [CFG_W-1:0] POINT_COUNT_RESET = 7'd64;

    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [SLOT_W-1:0]         slot;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
    } knp3_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     neighbor_index;
        logic [RANK_W-1:0]     neighbor_rank;
        logic [DIST_OUT_W-1:0] distance_squared;
        logic                  last;
    } knp3_result_t;

    // control part of a classified command
    typedef struct packed {
        logic              query;
        logic [SLOT_W-1:0] slot;
    } knp3_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QPT,
        ST_SCAN,
        ST_EMIT
    } knp3_state_t;

endpackage

>>> sv/k_nearest_points_3d_core.sv
// Brute-force 3D k-nearest-neighbor engine. A load beat (mode 0) writes a point
// into a slot of the on-chip store; a query beat (mode 1) names a stored point,
// scans slots 0 .. point_count-1 (skipping itself) and returns up to NEIGHBORS
// results nearest first, each with slot, rank and squared Euclidean distance;
// the final one has last set, and a query with no candidate returns nothing.
// Ties go to the lower slot. Beats whose slot is at or above MAX_POINTS are
// taken and dropped. Input beats land in a 2-deep command queue, so the input
// keeps taking beats until the queue is full while results wait to be popped.
// A load is written to the store as the back end pops it; a query fetches its
// query point, reads the store once per scanned slot, drains a 4-stage distance
// pipeline and then gives one result per pop of the output. The
// single read port of the point store sets the scan rate. Store slots have no
// reset and must be loaded before a query touches them. point_count is a
// 7-bit register, reset to 64, values above MAX_POINTS act as MAX_POINTS;
// write it only while no query is in flight.
module k_nearest_points_3d_core #(
    parameter int MAX_POINTS = 64,
    parameter int NEIGHBORS  = 3,
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  knp3_pkg::knp3_item_t        item,
    output logic                        empty,
    input  logic                        pop,
    output knp3_pkg::knp3_result_t      result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [knp3_pkg::CFG_W-1:0]  cfg_data
);
    import knp3_pkg::*;

    logic [CFG_W-1:0]      point_count_reg;
    logic [CFG_W-1:0]      point_count_next;
    logic                  cmd_valid;
    logic                  cmd_pop;
    knp3_cmd_t             cmd;
    logic [COORD_BITS-1:0] cmd_x, cmd_y, cmd_z;

    // config beat always taken
    assign cfg_ready        = 1'b1;
    assign point_count_next = (cfg_valid && cfg_ready) ? cfg_data : point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
        end
        else
        begin
            point_count_reg <= point_count_next;
        end
    end

    // front: takes beats, drops out-of-range slots, formats coordinates
    knp3_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y),
        .cmd_z     (cmd_z),
        .cmd_pop   (cmd_pop)
    );

    // back: point store, distance pipeline, best list and result emit
    knp3_back #(
        .MAX_POINTS (MAX_POINTS),
        .NEIGHBORS  (NEIGHBORS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_x       (cmd_x),
        .cmd_y       (cmd_y),
        .cmd_z       (cmd_z),
        .cmd_pop     (cmd_pop),
        .point_count (point_count_reg),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

>>> sv/knp3_ram.sv
module knp3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/knp3_front.sv
module knp3_front #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  knp3_pkg::knp3_item_t    item,
    output logic                    cmd_valid,
    output knp3_pkg::knp3_cmd_t     cmd,
    output logic [COORD_BITS-1:0]   cmd_x,
    output logic [COORD_BITS-1:0]   cmd_y,
    output logic [COORD_BITS-1:0]   cmd_z,
    input  logic                    cmd_pop
);
    import knp3_pkg::*;

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    knp3_cmd_t             q_cmd_reg [QD];
    logic [COORD_BITS-1:0] q_x_reg [QD];
    logic [COORD_BITS-1:0] q_y_reg [QD];
    logic [COORD_BITS-1:0] q_z_reg [QD];

    logic                         keep;
    logic                         enq;
    logic                         deq;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    knp3_cmd_t                    cmd_in;

    // slots beyond the store are dropped here; beat still taken
    assign keep = int'(item.slot) < MAX_POINTS;
    assign enq  = push && !full && keep;
    assign deq  = cmd_pop && cmd_valid;

    // sign-extend or wrap to the internal coordinate width
    assign cx = COORD_BITS'(item.pos_x);
    assign cy = COORD_BITS'(item.pos_y);
    assign cz = COORD_BITS'(item.pos_z);

    assign cmd_in.query = (item.mode == MODE_QUERY);
    assign cmd_in.slot  = item.slot;

    assign full      = (cnt_reg == QCW'(QD));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_x     = q_x_reg[rd_ptr_reg];
    assign cmd_y     = q_y_reg[rd_ptr_reg];
    assign cmd_z     = q_z_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (!enq && deq)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_cmd_reg[wr_ptr_reg] <= cmd_in;
            q_x_reg[wr_ptr_reg]   <= cx;
            q_y_reg[wr_ptr_reg]   <= cy;
            q_z_reg[wr_ptr_reg]   <= cz;
        end
    end

endmodule

>>> sv/knp3_back.sv
module knp3_back #(
    parameter int MAX_POINTS = 64,
    parameter int NEIGHBORS  = 3,
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  knp3_pkg::knp3_cmd_t         cmd,
    input  logic [COORD_BITS-1:0]       cmd_x,
    input  logic [COORD_BITS-1:0]       cmd_y,
    input  logic [COORD_BITS-1:0]       cmd_z,
    output logic                        cmd_pop,
    input  logic [knp3_pkg::CFG_W-1:0]  point_count,
    output logic                        empty,
    input  logic                        pop,
    output knp3_pkg::knp3_result_t      result
);
    import knp3_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SQW = 2 * COORD_BITS;
    localparam int DW  = 2 * COORD_BITS + 2;
    localparam int NW  = $clog2(NEIGHBORS + 1);
    localparam int IW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int PW  = 3 * COORD_BITS;

    knp3_state_t state_reg, state_next;

    logic [AW-1:0] qslot_reg, qslot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [IW-1:0] emit_reg, emit_next;
    logic [IW-1:0] last_idx;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    logic          issue;
    logic          clear_best;
    logic          pipe_busy;

    // query point
    logic [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;

    // distance pipeline
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]         slot1_reg, slot2_reg, slot3_reg, slot4_reg;
    logic [COORD_BITS-1:0] adx_reg, ady_reg, adz_reg;
    logic [SQW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [DW-1:0]         dist4_reg;

    // sorted best list, nearest first
    logic [DW-1:0]  best_dist_reg [NEIGHBORS];
    logic [AW-1:0]  best_slot_reg [NEIGHBORS];
    logic [DW-1:0]  best_dist_next [NEIGHBORS];
    logic [AW-1:0]  best_slot_next [NEIGHBORS];
    logic [NW-1:0]  best_cnt_reg, best_cnt_next;
    logic [DW-1:0]  dist_ext [NEIGHBORS+1];
    logic [AW-1:0]  slot_ext [NEIGHBORS+1];
    logic [NEIGHBORS-1:0] goes_ahead;
    logic [NEIGHBORS:0]   ahead_ext;

    knp3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd.slot)),
        .wdata ({cmd_x, cmd_y, cmd_z}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] n;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        n = -d;
        return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign last_idx  = IW'(best_cnt_reg - NW'(1));

    always_comb
    begin
        state_next = state_reg;
        qslot_next = qslot_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        emit_next  = emit_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = qslot_reg;
        issue      = 1'b0;
        clear_best = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.query)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(cmd.slot);
                        qslot_next = AW'(cmd.slot);
                        count_next = (int'(point_count) > MAX_POINTS) ?
                                     CW'(MAX_POINTS) : CW'(point_count);
                        scan_next  = '0;
                        clear_best = 1'b1;
                        state_next = ST_QPT;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_QPT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_reg != count_reg)
                begin
                    issue     = 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + CW'(1);
                end
                else if (!pipe_busy)
                begin
                    emit_next  = '0;
                    state_next = (best_cnt_reg == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    if (emit_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ordered insert; equal distances stay behind earlier (lower) slots
    always_comb
    begin
        dist_ext[0] = dist4_reg;
        slot_ext[0] = slot4_reg;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            dist_ext[i+1] = best_dist_reg[i];
            slot_ext[i+1] = best_slot_reg[i];
            goes_ahead[i] = (NW'(i) >= best_cnt_reg) || (dist4_reg < best_dist_reg[i]);
        end
        ahead_ext = {goes_ahead, 1'b0};
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            best_dist_next[i] = best_dist_reg[i];
            best_slot_next[i] = best_slot_reg[i];
            if (v4_reg && goes_ahead[i])
            begin
                if (ahead_ext[i])
                begin
                    best_dist_next[i] = dist_ext[i];
                    best_slot_next[i] = slot_ext[i];
                end
                else
                begin
                    best_dist_next[i] = dist4_reg;
                    best_slot_next[i] = slot4_reg;
                end
            end
        end
        best_cnt_next = best_cnt_reg;
        if (clear_best)
        begin
            best_cnt_next = '0;
        end
        else if (v4_reg && goes_ahead[NEIGHBORS-1] && (best_cnt_reg != NW'(NEIGHBORS)))
        begin
            best_cnt_next = best_cnt_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            qslot_reg    <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            emit_reg     <= '0;
            best_cnt_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            qslot_reg    <= qslot_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            emit_reg     <= emit_next;
            best_cnt_reg <= best_cnt_next;
            v1_reg       <= issue && (scan_reg[AW-1:0] != qslot_reg);
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_QPT)
        begin
            {qx_reg, qy_reg, qz_reg} <= ram_rdata;
        end
        slot1_reg <= scan_reg[AW-1:0];
        slot2_reg <= slot1_reg;
        slot3_reg <= slot2_reg;
        slot4_reg <= slot3_reg;
        adx_reg   <= abs_diff(ram_rdata[PW-1 -: COORD_BITS], qx_reg);
        ady_reg   <= abs_diff(ram_rdata[2*COORD_BITS-1 -: COORD_BITS], qy_reg);
        adz_reg   <= abs_diff(ram_rdata[COORD_BITS-1:0], qz_reg);
        sqx_reg   <= SQW'(adx_reg) * SQW'(adx_reg);
        sqy_reg   <= SQW'(ady_reg) * SQW'(ady_reg);
        sqz_reg   <= SQW'(adz_reg) * SQW'(adz_reg);
        dist4_reg <= DW'(sqx_reg) + DW'(sqy_reg) + DW'(sqz_reg);
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            best_dist_reg[i] <= best_dist_next[i];
            best_slot_reg[i] <= best_slot_next[i];
        end
    end

    assign empty                   = (state_reg != ST_EMIT);
    assign result.neighbor_index   = SLOT_W'(best_slot_reg[emit_reg]);
    assign result.neighbor_rank    = RANK_W'(emit_reg);
    assign result.distance_squared = DIST_OUT_W'(best_dist_reg[emit_reg]);
    assign result.last             = (emit_reg == last_idx);

`ifndef SYNTHESIS
    a_best_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_cnt_reg <= NW'(NEIGHBORS))
        else $error("best list count over capacity");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (best_cnt_reg != '0) && (emit_reg <= last_idx))
        else $error("emit index outside best list");

    a_insert_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (state_reg == ST_SCAN))
        else $error("distance insert outside scan");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= count_reg)
        else $error("scan ran past point count");
`endif

endmodule
